/* rtl/grm_pkg.sv */
// Package for the gated RPM meter: state codes, register indexes and
// reset values. Used by gated_rpm_meter_core; depends on nothing.
`default_nettype none

package grm_pkg;

  localparam int unsigned TIME_W  = 32;
  localparam int unsigned SCALE_W = 48;
  localparam int unsigned PROD_W  = TIME_W + SCALE_W;  // 80-bit product
  localparam int unsigned ADD_W   = SCALE_W + 1;       // shared adder width
  localparam int unsigned ITER    = 32;                // steps per multiply / divide
  localparam int unsigned CNT_W   = 5;

  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GATE   = 2'd2;

  localparam logic [SCALE_W-1:0] SCALE_RST = 48'd65536000000;
  localparam logic [TIME_W-1:0]  GATE_RST  = 32'd100000;
  localparam logic [TIME_W-1:0]  RPM_MAX   = 32'hFFFF_FFFF;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_MUL  = 5'b00010,
    S_SAT  = 5'b00100,
    S_DIV  = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

endpackage

`default_nettype wire

/* rtl/gated_rpm_meter_core.sv */
// Gated RPM meter core: poll handling, configuration registers and the
// serial multiply / divide sequencer. Depends on grm_pkg.
`default_nettype none

// A poll that passes the gate is accepted, runs 32 shift-add steps for the
// pulse-difference times scale product and an overflow check, then, unless it
// overflows, 32 restoring-division steps by the elapsed time, and loads the
// result register; all steps run through one shared 49-bit adder. Polls that
// only prime the state or fail the gate finish in the accept cycle. A new poll
// is taken while a finished result still waits in the output register.
// Configuration writes are taken every cycle and should only be issued while
// the block is idle.
module gated_rpm_meter_core
  import grm_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [TIME_W-1:0]    in_now_usec,
  input  wire logic [TIME_W-1:0]    in_pulse_count,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [TIME_W-1:0]         out_rpm_value,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [SCALE_W-1:0]   cfg_data
);

  state_t              state_r, state_nxt;
  logic                enable_r;
  logic [SCALE_W-1:0]  scale_r;
  logic [TIME_W-1:0]   gate_r;
  logic [TIME_W-1:0]   last_time_r, last_time_nxt;
  logic [TIME_W-1:0]   last_count_r, last_count_nxt;
  logic                primed_r, primed_nxt;
  logic [TIME_W-1:0]   elap_r, elap_nxt;
  logic [PROD_W-1:0]   prod_r, prod_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic                sat_r, sat_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [TIME_W-1:0]   out_data_r, out_data_nxt;

  logic                in_acc;
  logic [TIME_W-1:0]   elapsed;
  logic [TIME_W-1:0]   diff;
  logic                gate_pass;

  logic [ADD_W-1:0]    add_a, add_b, add_sum;
  logic                add_cin;
  logic [TIME_W:0]     div_shift;

  assign in_ready  = (state_r == S_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_valid     = out_valid_r;
  assign out_rpm_value = out_data_r;

  assign elapsed   = in_now_usec - last_time_r;
  assign diff      = last_count_r - in_pulse_count;
  assign gate_pass = (elapsed > gate_r);

  // partial remainder shifted left with the next dividend bit
  assign div_shift = {prod_r[PROD_W-1 -: TIME_W], prod_r[PROD_W-TIME_W-1]};

  // shared adder: add scale for multiply, subtract elapsed for check/divide
  always_comb begin
    add_a   = '0;
    add_b   = '0;
    add_cin = 1'b0;
    case (state_r)
      S_MUL: begin
        add_a = {1'b0, prod_r[PROD_W-1 -: SCALE_W]};
        add_b = prod_r[0] ? {1'b0, scale_r} : '0;
      end
      S_SAT: begin
        add_a   = {{(ADD_W-TIME_W){1'b0}}, prod_r[PROD_W-1 -: TIME_W]};
        add_b   = ~{{(ADD_W-TIME_W){1'b0}}, elap_r};
        add_cin = 1'b1;
      end
      S_DIV: begin
        add_a   = {{(ADD_W-TIME_W-1){1'b0}}, div_shift};
        add_b   = ~{{(ADD_W-TIME_W){1'b0}}, elap_r};
        add_cin = 1'b1;
      end
      default: begin
        add_a   = '0;
        add_b   = '0;
        add_cin = 1'b0;
      end
    endcase
  end

  assign add_sum = add_a + add_b + {{(ADD_W-1){1'b0}}, add_cin};

  always_comb begin
    state_nxt      = state_r;
    last_time_nxt  = last_time_r;
    last_count_nxt = last_count_r;
    primed_nxt     = primed_r;
    elap_nxt       = elap_r;
    prod_nxt       = prod_r;
    cnt_nxt        = cnt_r;
    sat_nxt        = sat_r;
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_acc && enable_r) begin
          if (!primed_r) begin
            last_time_nxt  = in_now_usec;
            last_count_nxt = in_pulse_count;
            primed_nxt     = 1'b1;
          end else if ((scale_r != '0) && gate_pass) begin
            last_time_nxt  = in_now_usec;
            last_count_nxt = in_pulse_count;
            elap_nxt       = elapsed;
            prod_nxt       = {{SCALE_W{1'b0}}, diff};
            cnt_nxt        = '0;
            state_nxt      = S_MUL;
          end
        end
      end
      S_MUL: begin
        // leave the 16 fraction bits below the dividend, which is prod_r[79:16]
        prod_nxt = {add_sum, prod_r[TIME_W-1:1]};
        cnt_nxt  = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(ITER - 1)) begin
          state_nxt = S_SAT;
        end
      end
      S_SAT: begin
        // quotient overflows when the upper half is not below the divisor
        sat_nxt   = ~add_sum[ADD_W-1];
        cnt_nxt   = '0;
        state_nxt = add_sum[ADD_W-1] ? S_DIV : S_DONE;
      end
      S_DIV: begin
        if (!add_sum[ADD_W-1]) begin
          prod_nxt[PROD_W-1 -: TIME_W] = add_sum[TIME_W-1:0];
        end else begin
          prod_nxt[PROD_W-1 -: TIME_W] = div_shift[TIME_W-1:0];
        end
        prod_nxt[PROD_W-TIME_W-1 -: TIME_W] =
          {prod_r[PROD_W-TIME_W-2 -: TIME_W-1], ~add_sum[ADD_W-1]};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(ITER - 1)) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        // hold until the output register is free
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = sat_r ? RPM_MAX : prod_r[PROD_W-TIME_W-1 -: TIME_W];
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      enable_r     <= 1'b0;
      scale_r      <= SCALE_RST;
      gate_r       <= GATE_RST;
      last_time_r  <= '0;
      last_count_r <= '0;
      primed_r     <= 1'b0;
      out_valid_r  <= 1'b0;
      cnt_r        <= '0;
      sat_r        <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      last_time_r  <= last_time_nxt;
      last_count_r <= last_count_nxt;
      primed_r     <= primed_nxt;
      out_valid_r  <= out_valid_nxt;
      cnt_r        <= cnt_nxt;
      sat_r        <= sat_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_ENABLE: enable_r <= cfg_data[0];
          CFG_SCALE:  scale_r  <= cfg_data;
          CFG_GATE:   gate_r   <= cfg_data[TIME_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    elap_r     <= elap_nxt;
    prod_r     <= prod_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

`default_nettype wire

/* tb/gated_rpm_meter_core_tb.sv */
// Self-checking testbench for gated_rpm_meter_core: directed polls, then gated
// random polls under several register settings and handshake idling patterns.
// Depends on grm_pkg and the gated_rpm_meter_core RTL.
module gated_rpm_meter_core_tb;
  import grm_pkg::*;

  localparam int unsigned CLK_HALF     = 10;
  localparam int unsigned DRAIN_CYCLES = 80;
  localparam int unsigned CYCLE_LIMIT  = 1000000;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [TIME_W-1:0]    in_now_usec = '0;
  logic [TIME_W-1:0]    in_pulse_count = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [TIME_W-1:0]    out_rpm_value;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [SCALE_W-1:0]   cfg_data = '0;

  // Predictor copy of registers and poll state
  logic                 pred_enable;
  logic [SCALE_W-1:0]   pred_scale;
  logic [TIME_W-1:0]    pred_gate;
  logic [TIME_W-1:0]    pred_last_time;
  logic [TIME_W-1:0]    pred_last_count;
  logic                 pred_primed;

  logic [TIME_W-1:0]    rpm_expected[$];
  int                   error_count = 0;
  int                   cycle_count = 0;
  int                   send_idle_pct = 0;
  int                   recv_idle_pct = 0;

  gated_rpm_meter_core u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_now_usec    (in_now_usec),
    .in_pulse_count (in_pulse_count),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_rpm_value  (out_rpm_value),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  initial begin
    forever #(CLK_HALF) clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin : rpm_check
    logic [TIME_W-1:0] want;
    if (rst_n && out_valid && out_ready) begin
      if (rpm_expected.size() == 0) begin
        $error("unexpected result: rpm_value actual %0d", out_rpm_value);
        error_count++;
      end else begin
        want = rpm_expected.pop_front();
        if (out_rpm_value !== want) begin
          $error("rpm_value mismatch: expected %0d, actual %0d", want, out_rpm_value);
          error_count++;
        end
      end
    end
  end

  // floor(diff * scale / (elapsed * 2^16)), saturated to 32 bits
  function automatic logic [TIME_W-1:0] scaled_rpm(input logic [TIME_W-1:0] diff,
                                                   input logic [SCALE_W-1:0] scale,
                                                   input logic [TIME_W-1:0] elapsed);
    logic [PROD_W-1:0] prod;
    logic [PROD_W-1:0] den;
    logic [PROD_W-1:0] quo;
    prod = {{SCALE_W{1'b0}}, diff} * {{TIME_W{1'b0}}, scale};
    den  = {{(PROD_W-TIME_W-16){1'b0}}, elapsed, 16'h0000};
    quo  = prod / den;
    return (quo > {{(PROD_W-TIME_W){1'b0}}, RPM_MAX}) ? RPM_MAX : quo[TIME_W-1:0];
  endfunction

  task automatic predict_poll(input logic [TIME_W-1:0] now_usec,
                              input logic [TIME_W-1:0] pulse_count);
    logic [TIME_W-1:0] elapsed;
    elapsed = now_usec - pred_last_time;
    if (!pred_enable) return;
    if (!pred_primed) begin
      pred_last_time  = now_usec;
      pred_last_count = pulse_count;
      pred_primed     = 1'b1;
      return;
    end
    if (pred_scale == '0) return;
    if (elapsed <= pred_gate) return;
    rpm_expected.push_back(scaled_rpm(pred_last_count - pulse_count, pred_scale, elapsed));
    pred_last_time  = now_usec;
    pred_last_count = pulse_count;
  endtask

  task automatic send_poll(input logic [TIME_W-1:0] now_usec,
                           input logic [TIME_W-1:0] pulse_count);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_now_usec    <= now_usec;
    in_pulse_count <= pulse_count;
    do @(posedge clk); while (!in_ready);
    predict_poll(now_usec, pulse_count);
  endtask

  // Hold polls off until every pending speed has been delivered
  task automatic wait_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (rpm_expected.size() != 0);
  endtask

  task automatic wait_idle();
    wait_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [SCALE_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_ENABLE: pred_enable = data[0];
      CFG_SCALE:  pred_scale  = data;
      CFG_GATE:   pred_gate   = data[TIME_W-1:0];
      default: ;
    endcase
  endtask

  task automatic cfg_release();
    cfg_valid <= 1'b0;
  endtask

  // Reset leaves the block disabled; a write with bit 0 clear keeps it so
  task automatic test_disabled();
    cfg_write(CFG_ENABLE, 48'hFFFF_FFFF_FFFE);
    cfg_release();
    send_poll(32'hFFFF_FFFF, 32'h0000_0000);
    send_poll(32'h0000_0000, 32'hFFFF_FFFF);
  endtask

  // Prime, then hit the gate exactly, then pass it with time and count wrapping
  task automatic test_first_poll();
    wait_idle();
    cfg_write(CFG_ENABLE, 48'd1);
    cfg_release();
    send_poll(32'hFFFF_0000, 32'h0000_0000);
    send_poll(32'hFFFF_0000 + 32'd100000, 32'hFFFF_F000);
    send_poll(32'hFFFF_0000 + 32'd100001, 32'hFFFF_FC18);
  endtask

  task automatic test_enable_hold();
    wait_idle();
    cfg_write(CFG_ENABLE, 48'd0);
    cfg_release();
    send_poll($urandom, $urandom);
    wait_idle();
    cfg_write(CFG_ENABLE, 48'd1);
    cfg_release();
    send_poll(pred_last_time + 32'd200000, pred_last_count - 32'd5);
  endtask

  task automatic test_zero_scale();
    wait_idle();
    cfg_write(CFG_SCALE, 48'd0);
    cfg_release();
    send_poll(pred_last_time + 32'h8000_0000, pred_last_count - 32'd77);
  endtask

  task automatic test_saturation();
    wait_idle();
    cfg_write(CFG_SCALE, 48'hFFFF_FFFF_FFFF);
    cfg_write(CFG_GATE, 48'd0);
    cfg_release();
    send_poll(pred_last_time + 32'd1, pred_last_count - 32'hFFFF_FFFF);
    send_poll(pred_last_time + 32'hFFFF_FFFF, pred_last_count);
  endtask

  // Zero gate: equal time is held back, one microsecond passes
  task automatic test_zero_gate();
    send_poll(pred_last_time, pred_last_count - 32'd3);
    send_poll(pred_last_time + 32'd1, pred_last_count - 32'd1);
  endtask

  task automatic test_truncation();
    wait_idle();
    cfg_write(CFG_SCALE, 48'd1);
    cfg_write(CFG_GATE, 48'd1);
    cfg_release();
    send_poll(pred_last_time + 32'd2, pred_last_count - 32'd1);
    wait_idle();
    cfg_write(CFG_SCALE, 48'd196608);
    cfg_write(CFG_GATE, 48'd6);
    cfg_release();
    send_poll(pred_last_time + 32'd7, pred_last_count - 32'd10);
  endtask

  task automatic test_gate_max();
    wait_idle();
    cfg_write(CFG_GATE, 48'hABCD_FFFF_FFFF);
    cfg_write(CFG_SPARE, SCALE_W'({$urandom, $urandom}));
    cfg_release();
    send_poll(pred_last_time + 32'hFFFF_FFFF, pred_last_count - 32'd5);
  endtask

  task automatic test_random(input int n_items, input int hold_at);
    logic [SCALE_W-1:0] scale;
    logic [SCALE_W-1:0] gate_raw;
    logic [SCALE_W-1:0] en_raw;
    logic [63:0]        step;
    logic [TIME_W-1:0]  now_usec;
    logic [TIME_W-1:0]  diff;
    int                 sent;
    case ($urandom_range(5))
      0: scale = 48'hFFFF_FFFF_FFFF;
      1: scale = SCALE_RST;
      2: scale = SCALE_W'({$urandom, $urandom});
      3: scale = SCALE_W'($urandom_range(1, 655360));
      4: scale = 48'd65536 * SCALE_W'($urandom_range(1, 1000000));
      default: scale = 48'd1;
    endcase
    case ($urandom_range(5))
      0: gate_raw = SCALE_W'({$urandom, 32'd0});
      1: gate_raw = 48'd1;
      2: gate_raw = SCALE_W'({$urandom, 32'd0}) | SCALE_W'($urandom_range(1, 5000));
      3: gate_raw = GATE_RST;
      4: gate_raw = SCALE_W'($urandom_range(5000, 2000000));
      default: gate_raw = SCALE_W'({$urandom, $urandom});
    endcase
    en_raw = SCALE_W'({$urandom, $urandom});
    en_raw[0] = ($urandom_range(9) != 0);
    wait_idle();
    cfg_write(CFG_ENABLE, en_raw);
    cfg_write(CFG_SCALE, scale);
    cfg_write(CFG_GATE, gate_raw);
    cfg_release();
    sent = 0;
    while (sent < n_items) begin
      case ($urandom_range(9))
        0, 1, 2: step = 64'($urandom_range(0, pred_gate));
        3:       step = 64'($urandom);
        default: begin
          step = 64'(pred_gate) + 64'd1 + 64'($urandom_range(0, 1000));
          if (step > 64'(RPM_MAX)) step = 64'(RPM_MAX);
        end
      endcase
      case ($urandom_range(9))
        0:       diff = '0;
        1, 2:    diff = $urandom;
        default: diff = $urandom_range(0, 100000);
      endcase
      now_usec = pred_last_time + step[TIME_W-1:0];
      if ($urandom_range(19) == 0) begin
        send_poll($urandom, $urandom);
      end else begin
        send_poll(now_usec, pred_last_count - diff);
      end
      sent++;
      if (sent == hold_at) wait_results();
    end
  endtask

  initial begin
    pred_enable     = 1'b0;
    pred_scale      = SCALE_RST;
    pred_gate       = GATE_RST;
    pred_last_time  = '0;
    pred_last_count = '0;
    pred_primed     = 1'b0;
    send_idle_pct   = 21;
    recv_idle_pct   = 67;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_disabled();
    test_first_poll();
    test_enable_hold();
    test_zero_scale();
    test_saturation();
    test_zero_gate();
    test_truncation();
    test_gate_max();

    for (int seg = 0; seg < 10; seg++) begin
      if (seg < 3) begin
        send_idle_pct = 21;
        recv_idle_pct = 67;
      end else if (seg < 6) begin
        send_idle_pct = 67;
        recv_idle_pct = 21;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      test_random(115, (seg == 0) ? 57 : -1);
    end

    wait_idle();
    if (error_count == 0 && rpm_expected.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/grm_pkg.sv
rtl/gated_rpm_meter_core.sv
tb/gated_rpm_meter_core_tb.sv
